### src/lnd_pkg.sv
// shared types, constants and fixed-point helpers of the landau stencil update
package lnd_pkg;

    localparam int DATA_W   = 32;
    localparam int STEN_W   = 37;
    localparam int PROD_W   = 2 * STEN_W;
    localparam int WIDE_W   = 80;
    localparam int CFG_IDX_W = 3;
    localparam int LAST_STEP = 24;
    localparam int LAST_READ = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RK_KEEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RK_SLOPE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RK_STAGE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DV    = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_STEN,
        ST_MUL,
        ST_WB,
        ST_DONE
    } t_state;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sd2147483647);
        lo = WIDE_W'(-64'sd2147483648);
        if (v > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

    // (a + b) mod 5 for a, b below 5
    function automatic logic [2:0] mod5add(input logic [2:0] a, input logic [2:0] b);
        logic [3:0] s;
        s = 4'(a) + 4'(b);
        mod5add = (s >= 4'd5) ? 3'(s - 4'd5) : s[2:0];
    endfunction

    // fourth-order central difference numerator
    function automatic logic signed [STEN_W-1:0] sten(
        input logic signed [DATA_W-1:0] m2,
        input logic signed [DATA_W-1:0] m1,
        input logic signed [DATA_W-1:0] p1,
        input logic signed [DATA_W-1:0] p2
    );
        logic signed [STEN_W-1:0] d1;
        logic signed [STEN_W-1:0] d2;
        d1 = STEN_W'(p1) - STEN_W'(m1);
        d2 = STEN_W'(p2) - STEN_W'(m2);
        sten = (d1 <<< 3) - d2;
    endfunction

endpackage

### src/lnd_qmul.sv
// registered signed multiplier with floor shift by 16 and 32-bit saturation
module lnd_qmul (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [lnd_pkg::STEN_W-1:0] i_a,
    input  logic signed [lnd_pkg::STEN_W-1:0] i_b,
    output logic signed [lnd_pkg::DATA_W-1:0] o_q
);
    import lnd_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] w_shift;

    // product register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    // arithmetic shift rounds toward minus infinity
    assign w_shift = r_prod >>> 16;
    assign o_q     = sat32(WIDE_W'(w_shift));
endmodule

### src/landau_stencil_rk_update.sv
// top level of the landau stencil runge-kutta stage update
//
// Input items arrive on the s channel, one grid point each, in raster order over
// the whole plane with halo rows and columns; tlast marks the final point and
// returns the position counters to the origin. Each point is stored in the row
// memories in the cycle it is accepted. For an interior centre point (two rows
// and two columns back) the block then reads its stencil neighbours, one memory
// read per cycle, forms the stencils and runs 25 products through one shared
// multiplier, each in a multiply state and then a write-back state. The block
// takes no new item until that result is loaded into the output register; an
// item without a result leaves the block ready for the next. The result (updated
// ft, fss, last flag) waits in the m channel output
// register; a stalled receiver holds it, and the next item is still accepted
// while it waits. Configuration writes are taken at any time on the cfg channel.
// Synchronous active-low reset clears the position counters, the control state
// and the registers to their reset values; the row memories are not cleared.
module landau_stencil_rk_update #(
    parameter int INTERIOR_X = 64,
    parameter int INTERIOR_V = 64,
    parameter int HALO       = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // dist_re, dist_im, equil_re, equil_im, base_re, base_im, accum_re, accum_im,
    // potential_re, potential_im, velocity
    input  logic [11*lnd_pkg::DATA_W-1:0]    i_s_tdata,
    input  logic                             i_s_tlast,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // new_accum_re, new_accum_im, stage_re, stage_im
    output logic [4*lnd_pkg::DATA_W-1:0]     o_m_tdata,
    output logic                             o_m_tlast,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lnd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lnd_pkg::DATA_W-1:0]       i_cfg_data
);
    import lnd_pkg::*;

    localparam int ROW_W = INTERIOR_V + 2 * HALO;
    localparam int ROW_H = INTERIOR_X + 2 * HALO;
    localparam int CW    = $clog2(ROW_W);
    localparam int RW    = $clog2(ROW_H);
    localparam int DA    = $clog2(5 * ROW_W);
    localparam int TA    = $clog2(3 * ROW_W);
    localparam int VA    = (ROW_W > 1) ? $clog2(ROW_W) : 1;

    // configuration registers
    logic signed [DATA_W-1:0] r_alpha, r_step_size, r_rk_keep, r_rk_slope, r_rk_stage;
    logic signed [DATA_W-1:0] r_inv_dx, r_inv_dv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= 32'sd65536;
            r_step_size <= '0;
            r_rk_keep   <= '0;
            r_rk_slope  <= 32'sd65536;
            r_rk_stage  <= '0;
            r_inv_dx    <= 32'sd5461;
            r_inv_dv    <= 32'sd5461;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ALPHA:     r_alpha     <= i_cfg_data;
                REG_STEP_SIZE: r_step_size <= i_cfg_data;
                REG_RK_KEEP:   r_rk_keep   <= i_cfg_data;
                REG_RK_SLOPE:  r_rk_slope  <= i_cfg_data;
                REG_RK_STAGE:  r_rk_stage  <= i_cfg_data;
                REG_INV_DX:    r_inv_dx    <= i_cfg_data;
                REG_INV_DV:    r_inv_dv    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    t_state r_state, n_state;
    logic [3:0] r_rd_cnt;
    logic [4:0] r_step;
    logic [CW-1:0] r_col, r_c_item;
    logic [RW-1:0] r_row, r_r_item;
    logic [2:0] r_slot5, r_s5_item;
    logic [1:0] r_slot3, r_s3_item;
    logic w_accept, w_interior, w_out_free;
    logic w_load_out, w_mul_en;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_interior = (32'(r_row) >= 32'd4) && (32'(r_col) >= 32'd4);
    assign w_out_free = !o_m_tvalid || i_m_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept && w_interior) n_state = ST_READ;
            ST_READ: if (r_rd_cnt == 4'(LAST_READ)) n_state = ST_STEN;
            ST_STEN: n_state = ST_MUL;
            ST_MUL:  n_state = ST_WB;
            ST_WB:   n_state = (r_step == 5'(LAST_STEP)) ? ST_DONE : ST_MUL;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_load_out = 1'b0;
        w_mul_en   = 1'b0;
        unique case (r_state)
            ST_IDLE: o_s_tready = 1'b1;
            ST_MUL:  w_mul_en   = 1'b1;
            ST_DONE: w_load_out = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_cnt <= '0;
            r_step   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_READ) begin
                r_rd_cnt <= r_rd_cnt + 4'd1;
            end else begin
                r_rd_cnt <= '0;
            end
            if (r_state == ST_WB) begin
                r_step <= r_step + 5'd1;
            end else if (r_state != ST_MUL) begin
                r_step <= '0;
            end
        end
    end

    // position counters with mod 5 and mod 3 row slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_slot5 <= '0;
            r_slot3 <= '0;
        end else if (w_accept) begin
            if (i_s_tlast || (32'(r_col) == ROW_W - 1 && 32'(r_row) == ROW_H - 1)) begin
                r_col   <= '0;
                r_row   <= '0;
                r_slot5 <= '0;
                r_slot3 <= '0;
            end else if (32'(r_col) == ROW_W - 1) begin
                r_col   <= '0;
                r_row   <= r_row + RW'(1);
                r_slot5 <= mod5add(r_slot5, 3'd1);
                r_slot3 <= (r_slot3 == 2'd2) ? 2'd0 : r_slot3 + 2'd1;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // position of the item being worked on
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_c_item  <= r_col;
            r_r_item  <= r_row;
            r_s5_item <= r_slot5;
            r_s3_item <= r_slot3;
        end
    end

    // memories
    logic [63:0] m_dist  [5*ROW_W];
    logic [63:0] m_equil [3*ROW_W];
    logic [63:0] m_base  [3*ROW_W];
    logic [63:0] m_accum [3*ROW_W];
    logic [31:0] m_vel   [ROW_W];
    logic [63:0] m_pot   [5];

    logic [DA-1:0] w_dist_wa, w_dist_ra;
    logic [TA-1:0] w_tri_wa, w_tri_ra;
    logic [2:0]    w_back, w_pot_ra;
    logic [CW-1:0] w_rd_col, w_cc;
    logic [1:0]    w_d3;
    logic [63:0]   r_dist_rd, r_equil_rd, r_base_rd, r_accum_rd, r_pot_rd;
    logic [31:0]   r_vel_rd;
    logic          w_rd_lo;

    assign w_dist_wa = DA'(r_slot5) * DA'(ROW_W) + DA'(r_col);
    assign w_tri_wa  = TA'(r_slot3) * TA'(ROW_W) + TA'(r_col);
    assign w_cc      = r_c_item - CW'(2);
    assign w_d3      = (r_s3_item == 2'd2) ? 2'd0 : r_s3_item + 2'd1;
    assign w_tri_ra  = TA'(w_d3) * TA'(ROW_W) + TA'(w_cc);
    assign w_rd_lo   = (r_state == ST_READ) && (r_rd_cnt == 4'd0);

    // neighbour row and column for each read step
    always_comb begin
        w_back   = 3'd2;
        w_rd_col = w_cc;
        w_pot_ra = r_s5_item;
        case (r_rd_cnt)
            4'd0: begin w_back = 3'd1; w_pot_ra = mod5add(r_s5_item, 3'd1); end
            4'd1: begin w_back = 3'd2; w_pot_ra = mod5add(r_s5_item, 3'd2); end
            4'd2: begin w_back = 3'd4; w_pot_ra = mod5add(r_s5_item, 3'd4); end
            4'd3: begin w_back = 3'd0; w_pot_ra = r_s5_item; end
            4'd4: begin w_back = 3'd3; w_rd_col = r_c_item - CW'(4); end
            4'd5: begin w_back = 3'd3; w_rd_col = r_c_item - CW'(3); end
            4'd6: begin w_back = 3'd3; w_rd_col = r_c_item - CW'(1); end
            4'd7: begin w_back = 3'd3; w_rd_col = r_c_item; end
            default: ;
        endcase
    end
    // w_back holds the slot offset (r + offset) mod 5, i.e. 5 minus rows back
    assign w_dist_ra = DA'(mod5add(r_s5_item, w_back)) * DA'(ROW_W) + DA'(w_rd_col);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            m_dist[w_dist_wa]  <= i_s_tdata[63:0];
            m_equil[w_tri_wa]  <= i_s_tdata[127:64];
            m_base[w_tri_wa]   <= i_s_tdata[191:128];
            m_accum[w_tri_wa]  <= i_s_tdata[255:192];
            m_pot[r_slot5]     <= i_s_tdata[319:256];
            m_vel[VA'(r_col)]  <= i_s_tdata[351:320];
        end
        if (r_state == ST_READ) begin
            r_dist_rd <= m_dist[w_dist_ra];
            r_pot_rd  <= m_pot[w_pot_ra];
        end
        if (w_rd_lo) begin
            r_equil_rd <= m_equil[w_tri_ra];
            r_base_rd  <= m_base[w_tri_ra];
            r_accum_rd <= m_accum[w_tri_ra];
            r_vel_rd   <= m_vel[VA'(w_cc)];
        end
    end

    // capture of neighbours, one read behind
    logic [63:0] r_nb [8];
    logic [63:0] r_pw [4];
    logic [2:0]  w_cap;

    assign w_cap = 3'(r_rd_cnt - 4'd1);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ && r_rd_cnt != 4'd0) begin
            r_nb[w_cap] <= r_dist_rd;
            if (r_rd_cnt <= 4'd4) begin
                r_pw[w_cap[1:0]] <= r_pot_rd;
            end
        end
    end

    // stencil numerators
    logic signed [STEN_W-1:0] r_sp_re, r_sp_im, r_sx_re, r_sx_im, r_sv_re, r_sv_im;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_STEN) begin
            r_sp_re <= sten(r_pw[0][31:0], r_pw[1][31:0], r_pw[2][31:0], r_pw[3][31:0]);
            r_sp_im <= sten(r_pw[0][63:32], r_pw[1][63:32], r_pw[2][63:32], r_pw[3][63:32]);
            r_sx_re <= sten(r_nb[0][31:0], r_nb[1][31:0], r_nb[2][31:0], r_nb[3][31:0]);
            r_sx_im <= sten(r_nb[0][63:32], r_nb[1][63:32], r_nb[2][63:32], r_nb[3][63:32]);
            r_sv_re <= sten(r_nb[4][31:0], r_nb[5][31:0], r_nb[6][31:0], r_nb[7][31:0]);
            r_sv_im <= sten(r_nb[4][63:32], r_nb[5][63:32], r_nb[6][63:32], r_nb[7][63:32]);
        end
    end

    // shared multiplier
    logic signed [STEN_W-1:0] w_ma, w_mb;
    logic signed [DATA_W-1:0] w_q;
    logic signed [DATA_W-1:0] r_phr, r_phi, r_dxr, r_dxi, r_dvr, r_dvi, r_av, r_t0;
    logic signed [DATA_W-1:0] r_pr, r_pi, r_nr, r_ni, r_dgr, r_dgi, r_ftr, r_fti;
    logic signed [DATA_W-1:0] r_sr, r_si;
    logic signed [DATA_W-1:0] w_er, w_ei, w_ar, w_ai, w_br, w_bi, w_vel;

    assign w_er  = r_equil_rd[31:0];
    assign w_ei  = r_equil_rd[63:32];
    assign w_ar  = r_accum_rd[31:0];
    assign w_ai  = r_accum_rd[63:32];
    assign w_br  = r_base_rd[31:0];
    assign w_bi  = r_base_rd[63:32];
    assign w_vel = r_vel_rd;

    lnd_qmul u_qmul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_q   (w_q)
    );

    // operand selection per step
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_step)
            5'd0:  begin w_ma = r_sp_re;         w_mb = STEN_W'(r_inv_dx); end
            5'd1:  begin w_ma = r_sp_im;         w_mb = STEN_W'(r_inv_dx); end
            5'd2:  begin w_ma = r_sx_re;         w_mb = STEN_W'(r_inv_dx); end
            5'd3:  begin w_ma = r_sx_im;         w_mb = STEN_W'(r_inv_dx); end
            5'd4:  begin w_ma = r_sv_re;         w_mb = STEN_W'(r_inv_dv); end
            5'd5:  begin w_ma = r_sv_im;         w_mb = STEN_W'(r_inv_dv); end
            5'd6:  begin w_ma = STEN_W'(r_alpha);    w_mb = STEN_W'(w_vel); end
            5'd7:  begin w_ma = STEN_W'(w_er);       w_mb = STEN_W'(r_phr); end
            5'd8:  begin w_ma = STEN_W'(w_ei);       w_mb = STEN_W'(r_phi); end
            5'd9:  begin w_ma = STEN_W'(w_er);       w_mb = STEN_W'(r_phi); end
            5'd10: begin w_ma = STEN_W'(w_ei);       w_mb = STEN_W'(r_phr); end
            5'd11: begin w_ma = STEN_W'(r_phr);      w_mb = STEN_W'(r_dvr); end
            5'd12: begin w_ma = STEN_W'(r_phi);      w_mb = STEN_W'(r_dvi); end
            5'd13: begin w_ma = STEN_W'(r_phr);      w_mb = STEN_W'(r_dvi); end
            5'd14: begin w_ma = STEN_W'(r_phi);      w_mb = STEN_W'(r_dvr); end
            5'd15: begin w_ma = STEN_W'(r_av);       w_mb = STEN_W'(r_pr); end
            5'd16: begin w_ma = STEN_W'(r_av);       w_mb = STEN_W'(r_pi); end
            5'd17: begin w_ma = STEN_W'(r_rk_keep);  w_mb = STEN_W'(w_ar); end
            5'd18: begin w_ma = STEN_W'(r_rk_slope); w_mb = STEN_W'(r_dgr); end
            5'd19: begin w_ma = STEN_W'(r_rk_keep);  w_mb = STEN_W'(w_ai); end
            5'd20: begin w_ma = STEN_W'(r_rk_slope); w_mb = STEN_W'(r_dgi); end
            5'd21: begin w_ma = STEN_W'(r_rk_stage); w_mb = STEN_W'(r_ftr); end
            5'd22: begin w_ma = STEN_W'(r_step_size); w_mb = STEN_W'(r_t0); end
            5'd23: begin w_ma = STEN_W'(r_rk_stage); w_mb = STEN_W'(r_fti); end
            5'd24: begin w_ma = STEN_W'(r_step_size); w_mb = STEN_W'(r_t0); end
            default: ;
        endcase
    end

    // write-back and combining per step
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WB) begin
            case (r_step)
                5'd0:  r_phr <= w_q;
                5'd1:  r_phi <= w_q;
                5'd2:  r_dxr <= w_q;
                5'd3:  r_dxi <= w_q;
                5'd4:  r_dvr <= w_q;
                5'd5:  r_dvi <= w_q;
                5'd6:  r_av  <= w_q;
                5'd7:  r_t0  <= w_q;
                5'd8:  r_pr  <= sat32(WIDE_W'(r_dxr) + WIDE_W'(sat32(WIDE_W'(r_t0) - WIDE_W'(w_q))));
                5'd9:  r_t0  <= w_q;
                5'd10: r_pi  <= sat32(WIDE_W'(r_dxi) + WIDE_W'(sat32(WIDE_W'(r_t0) + WIDE_W'(w_q))));
                5'd11: r_t0  <= w_q;
                5'd12: r_nr  <= sat32(WIDE_W'(r_t0) - WIDE_W'(w_q));
                5'd13: r_t0  <= w_q;
                5'd14: r_ni  <= sat32(WIDE_W'(r_t0) + WIDE_W'(w_q));
                5'd15: r_dgr <= sat32(WIDE_W'(r_nr) - WIDE_W'(w_q));
                5'd16: r_dgi <= sat32(WIDE_W'(r_ni) - WIDE_W'(w_q));
                5'd17: r_t0  <= w_q;
                5'd18: r_ftr <= sat32(WIDE_W'(r_t0) + WIDE_W'(w_q));
                5'd19: r_t0  <= w_q;
                5'd20: r_fti <= sat32(WIDE_W'(r_t0) + WIDE_W'(w_q));
                5'd21: r_t0  <= sat32(WIDE_W'(w_q) + WIDE_W'(r_dgr));
                5'd22: r_sr  <= sat32(WIDE_W'(w_br) + WIDE_W'(w_q));
                5'd23: r_t0  <= sat32(WIDE_W'(w_q) + WIDE_W'(r_dgi));
                5'd24: r_si  <= sat32(WIDE_W'(w_bi) + WIDE_W'(w_q));
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (w_load_out) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            o_m_tdata <= {r_si, r_sr, r_fti, r_ftr};
            o_m_tlast <= (32'(r_r_item) == ROW_H - 1) && (32'(r_c_item) == ROW_W - 1);
        end
    end
endmodule

### tb/lnd_checker.sv
// checker for the landau stencil update: tracks the stream, predicts and compares results
`timescale 1ns / 100ps

module lnd_checker #(
    parameter int INTERIOR_X = 64,
    parameter int INTERIOR_V = 64,
    parameter int HALO       = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [11*lnd_pkg::DATA_W-1:0]  i_s_tdata,
    input  logic                           i_s_tlast,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [4*lnd_pkg::DATA_W-1:0]   i_m_tdata,
    input  logic                           i_m_tlast,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [lnd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lnd_pkg::DATA_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import lnd_pkg::*;

    localparam int ROW_W = INTERIOR_V + 2 * HALO;
    localparam int ROW_H = INTERIOR_X + 2 * HALO;

    typedef logic signed [DATA_W-1:0] t_q;
    typedef logic signed [79:0] t_wide;

    typedef struct packed {
        t_q   accum_re;
        t_q   accum_im;
        t_q   stage_re;
        t_q   stage_im;
        logic last;
    } t_update;

    // predicted register copy
    t_q alpha, step_size, rk_keep, rk_slope, rk_stage, inv_dx, inv_dv;

    // predicted grid stores
    t_q fs_re [5][ROW_W];
    t_q fs_im [5][ROW_W];
    t_q f0_re [3][ROW_W];
    t_q f0_im [3][ROW_W];
    t_q f1_re [3][ROW_W];
    t_q f1_im [3][ROW_W];
    t_q ft_re [3][ROW_W];
    t_q ft_im [3][ROW_W];
    t_q vel [ROW_W];
    t_q phi_re [5];
    t_q phi_im [5];
    int col, row;

    t_update updates_due[$];

    assign o_pending = updates_due.size();

    function automatic t_q clip(input t_wide v);
        if (v > t_wide'(64'sd2147483647)) return 32'sh7fffffff;
        if (v < t_wide'(-64'sd2147483648)) return 32'sh80000000;
        return v[31:0];
    endfunction

    // product shifted down by 16 with floor rounding, saturated
    function automatic t_q fx_mul(input t_wide a, input t_wide b);
        t_wide p;
        p = a * b;
        return clip(p >>> 16);
    endfunction

    function automatic t_q add_sat(input t_wide a, input t_wide b);
        return clip(a + b);
    endfunction

    function automatic t_q sub_sat(input t_wide a, input t_wide b);
        return clip(a - b);
    endfunction

    // fourth-order central difference numerator
    function automatic t_wide diff4(input t_wide m2, input t_wide m1, input t_wide p1,
                                    input t_wide p2);
        return 8 * (p1 - m1) - (p2 - m2);
    endfunction

    // stencil and runge-kutta update for the centre two rows and columns back
    function automatic t_update centre_update(input int r, input int c);
        t_update u;
        int cc, d3, pm2, pm1, pp1, pp2, xm2, xm1, xp1, xp2, vr;
        t_q phr, phi, dxr, dxi, dvr, dvi, av, pr, pi, nr, ni, dgr, dgi, ftr, fti;
        cc  = c - 2;
        d3  = (r + 1) % 3;
        pm2 = (r + 1) % 5;
        pm1 = (r + 2) % 5;
        pp1 = (r + 4) % 5;
        pp2 = r % 5;
        xm2 = (r + 1) % 5;
        xm1 = (r + 2) % 5;
        vr  = (r + 3) % 5;
        xp1 = (r + 4) % 5;
        xp2 = r % 5;
        phr = fx_mul(diff4(phi_re[pm2], phi_re[pm1], phi_re[pp1], phi_re[pp2]), inv_dx);
        phi = fx_mul(diff4(phi_im[pm2], phi_im[pm1], phi_im[pp1], phi_im[pp2]), inv_dx);
        dxr = fx_mul(diff4(fs_re[xm2][cc], fs_re[xm1][cc], fs_re[xp1][cc], fs_re[xp2][cc]),
                     inv_dx);
        dxi = fx_mul(diff4(fs_im[xm2][cc], fs_im[xm1][cc], fs_im[xp1][cc], fs_im[xp2][cc]),
                     inv_dx);
        dvr = fx_mul(diff4(fs_re[vr][cc-2], fs_re[vr][cc-1], fs_re[vr][cc+1],
                           fs_re[vr][cc+2]), inv_dv);
        dvi = fx_mul(diff4(fs_im[vr][cc-2], fs_im[vr][cc-1], fs_im[vr][cc+1],
                           fs_im[vr][cc+2]), inv_dv);
        av  = fx_mul(alpha, vel[cc]);
        // f0 * dphi_dx, then add df_dx
        pr  = sub_sat(fx_mul(f0_re[d3][cc], phr), fx_mul(f0_im[d3][cc], phi));
        pi  = add_sat(fx_mul(f0_re[d3][cc], phi), fx_mul(f0_im[d3][cc], phr));
        pr  = add_sat(dxr, pr);
        pi  = add_sat(dxi, pi);
        // dphi_dx * df_dv
        nr  = sub_sat(fx_mul(phr, dvr), fx_mul(phi, dvi));
        ni  = add_sat(fx_mul(phr, dvi), fx_mul(phi, dvr));
        dgr = sub_sat(nr, fx_mul(av, pr));
        dgi = sub_sat(ni, fx_mul(av, pi));
        ftr = add_sat(fx_mul(rk_keep, ft_re[d3][cc]), fx_mul(rk_slope, dgr));
        fti = add_sat(fx_mul(rk_keep, ft_im[d3][cc]), fx_mul(rk_slope, dgi));
        u.accum_re = ftr;
        u.accum_im = fti;
        u.stage_re = add_sat(f1_re[d3][cc],
                             fx_mul(step_size, add_sat(fx_mul(rk_stage, ftr), dgr)));
        u.stage_im = add_sat(f1_im[d3][cc],
                             fx_mul(step_size, add_sat(fx_mul(rk_stage, fti), dgi)));
        u.last = (r == ROW_H - 1) && (c == ROW_W - 1);
        return u;
    endfunction

    always @(posedge i_clk) begin
        t_update want;
        t_q got [4];
        t_q exp_f [4];
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            alpha     <= 65536;
            step_size <= 0;
            rk_keep   <= 0;
            rk_slope  <= 65536;
            rk_stage  <= 0;
            inv_dx    <= 5461;
            inv_dv    <= 5461;
            col       <= 0;
            row       <= 0;
            updates_due.delete();
            o_fail_count <= 0;
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ALPHA:     alpha     <= i_cfg_data;
                    REG_STEP_SIZE: step_size <= i_cfg_data;
                    REG_RK_KEEP:   rk_keep   <= i_cfg_data;
                    REG_RK_SLOPE:  rk_slope  <= i_cfg_data;
                    REG_RK_STAGE:  rk_stage  <= i_cfg_data;
                    REG_INV_DX:    inv_dx    <= i_cfg_data;
                    REG_INV_DV:    inv_dv    <= i_cfg_data;
                    default: ;
                endcase
            end
            // input item: store the point, predict, advance position
            if (i_s_tvalid && i_s_tready) begin
                fs_re[row % 5][col] = i_s_tdata[0*32 +: 32];
                fs_im[row % 5][col] = i_s_tdata[1*32 +: 32];
                f0_re[row % 3][col] = i_s_tdata[2*32 +: 32];
                f0_im[row % 3][col] = i_s_tdata[3*32 +: 32];
                f1_re[row % 3][col] = i_s_tdata[4*32 +: 32];
                f1_im[row % 3][col] = i_s_tdata[5*32 +: 32];
                ft_re[row % 3][col] = i_s_tdata[6*32 +: 32];
                ft_im[row % 3][col] = i_s_tdata[7*32 +: 32];
                phi_re[row % 5]     = i_s_tdata[8*32 +: 32];
                phi_im[row % 5]     = i_s_tdata[9*32 +: 32];
                vel[col]            = i_s_tdata[10*32 +: 32];
                if (row >= 4 && col >= 4) updates_due.push_back(centre_update(row, col));
                if (i_s_tlast) begin
                    col <= 0;
                    row <= 0;
                end else if (col == ROW_W - 1) begin
                    col <= 0;
                    row <= (row == ROW_H - 1) ? 0 : row + 1;
                end else begin
                    col <= col + 1;
                end
            end
            // result item: compare with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                if (updates_due.size() == 0) begin
                    $display("%0t: unexpected result %h last %b", $time, i_m_tdata, i_m_tlast);
                    errs++;
                end else begin
                    want = updates_due.pop_front();
                    exp_f = '{want.accum_re, want.accum_im, want.stage_re, want.stage_im};
                    for (int k = 0; k < 4; k++) begin
                        got[k] = i_m_tdata[k*32 +: 32];
                        if (got[k] !== exp_f[k]) begin
                            $display("%0t: field %0d expected %h actual %h", $time, k,
                                     exp_f[k], got[k]);
                            errs++;
                        end
                    end
                    if (i_m_tlast !== want.last) begin
                        $display("%0t: last_point expected %b actual %b", $time, want.last,
                                 i_m_tlast);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

### tb/tb.sv
// testbench top for the landau stencil update: stimulus, handshake pacing and verdict
`timescale 1ns / 100ps

module tb;
    import lnd_pkg::*;

    localparam int ROW_W = 68;
    localparam int ROW_H = 68;
    localparam int STALL_LIMIT = 20000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [11*DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [4*DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0]     cfg_data = '0;
    int                    fail_count;
    int                    pending;
    t_idle                 idle_mode = IDLE_NONE;
    int                    quiet_cycles = 0;

    // stimulus side raster position and per-plane, per-row values
    int                    pos_r = 0;
    int                    pos_c = 0;
    logic [31:0]           vel_col [ROW_W];
    logic [31:0]           pot_re;
    logic [31:0]           pot_im;

    landau_stencil_rk_update uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tdata(s_tdata), .i_s_tlast(s_tlast), .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .o_m_tdata(m_tdata), .o_m_tlast(m_tlast), .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    lnd_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tdata(s_tdata), .i_s_tlast(s_tlast), .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_m_tdata(m_tdata), .i_m_tlast(m_tlast), .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver pacing
    always @(posedge i_clk) begin
        if (idle_mode == IDLE_RECV) m_tready <= ($urandom_range(99) >= 82);
        else if (idle_mode == IDLE_BOTH) m_tready <= ($urandom_range(99) >= 21);
        else m_tready <= 1'b1;
    end

    // watchdog on cycles with no accepted item anywhere
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // value mix: extremes, full range, and small values that avoid saturation
    function automatic logic [31:0] rnd32(input bit extreme);
        case ($urandom_range(extreme ? 0 : 1, 4))
            0: case ($urandom_range(4))
                   0: return 32'h7fffffff;
                   1: return 32'h80000000;
                   2: return 32'h0;
                   3: return 32'hffffffff;
                   default: return 32'h1;
               endcase
            1: return $urandom;
            default: return $urandom_range(0, 1 << 19) - (1 << 18);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_point(input logic [11*DATA_W-1:0] data, input logic last);
        int idle_pct;
        idle_pct = (idle_mode == IDLE_SEND) ? 82 : (idle_mode == IDLE_BOTH) ? 21 : 0;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tdata  <= data;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // next point of the raster, optionally marked as the end of the plane
    task automatic send_next(input bit last, input bit extreme);
        logic [11*DATA_W-1:0] d;
        if (pos_r == 0 && pos_c == 0) begin
            for (int c = 0; c < ROW_W; c++) vel_col[c] = rnd32(extreme);
        end
        if (pos_c == 0) begin
            pot_re = rnd32(extreme);
            pot_im = rnd32(extreme);
        end
        for (int k = 0; k < 8; k++) d[k*32 +: 32] = rnd32(extreme);
        d[8*32 +: 32]  = pot_re;
        d[9*32 +: 32]  = pot_im;
        d[10*32 +: 32] = vel_col[pos_c];
        send_point(d, last);
        if (last) begin
            pos_r = 0;
            pos_c = 0;
        end else if (pos_c == ROW_W - 1) begin
            pos_c = 0;
            pos_r = (pos_r == ROW_H - 1) ? 0 : pos_r + 1;
        end else begin
            pos_c = pos_c + 1;
        end
    endtask

    task automatic send_run(input int n, input bit extreme);
        repeat (n) send_next(1'b0, extreme);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] regs [7];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < 7; p++) begin
            idle_mode = t_idle'(p % 4);
            // register set for this phase, extremes included
            for (int k = 0; k < 7; k++) begin
                case (p)
                    0: regs[k] = (k == 0 || k == 3) ? 32'd65536 : (k >= 5) ? 32'd5461 : 32'd0;
                    2: regs[k] = 32'h7fffffff;
                    3: regs[k] = 32'h80000000;
                    4: regs[k] = 32'h0;
                    5: regs[k] = $urandom;
                    default: regs[k] = $urandom_range(0, 1 << 18) - (1 << 17);
                endcase
            end
            write_reg(REG_ALPHA, regs[0]);
            write_reg(REG_STEP_SIZE, regs[1]);
            write_reg(REG_RK_KEEP, regs[2]);
            write_reg(REG_RK_SLOPE, regs[3]);
            write_reg(REG_RK_STAGE, regs[4]);
            write_reg(REG_INV_DX, regs[5]);
            write_reg(REG_INV_DV, regs[6]);
            if (p == 0) begin
                // plane ended early in the halo, then a fresh plane into the interior
                send_run(4, 1'b1);
                send_next(1'b1, 1'b1);
                send_run(4 * ROW_W + 20, 1'b1);
            end else begin
                // the same plane goes on under the new registers, across row boundaries
                send_run(80 + $urandom_range(0, 20), p == 5);
            end
            settle();
        end
        // plane ended early, then a short plane in the halo
        send_next(1'b1, 1'b0);
        send_run(10, 1'b0);
        send_next(1'b1, 1'b0);
        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### landau_stencil_rk_update.f
src/lnd_pkg.sv
src/lnd_qmul.sv
src/landau_stencil_rk_update.sv
tb/lnd_checker.sv
tb/tb.sv
